@@ rtl/cuet_pkg.sv @@
// Package for the closure update and error tracker.
// Holds payload structs, register indexes, closure codes and fixed-point constants.
// No dependencies.
package cuet_pkg;

   localparam int FracBits = 24;
   localparam logic signed [32:0] FxOne = 33'sd16777216;
   localparam logic [31:0] FxEps = 32'd17;
   localparam logic [30:0] Sat31 = 31'h7FFF_FFFF;
   localparam logic [31:0] Log2eQ30 = 32'd1549082005;
   localparam logic [31:0] Ln2Q30 = 32'd744261118;

   typedef enum logic [1:0] {
      CLOSURE_HNC = 2'd0,
      CLOSURE_PY  = 2'd1,
      CLOSURE_KH  = 2'd2,
      CLOSURE_RSV = 2'd3
   } closure_type;

   typedef enum logic [1:0] {
      REG_CLOSURE = 2'd0,
      REG_LIMIT   = 2'd1,
      REG_DAMPING = 2'd2,
      REG_UPDATE  = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic signed [31:0] t_value;
      logic signed [31:0] short_potential;
      logic signed [31:0] c_old;
      logic pair_enabled;
      logic last_point;
      logic new_sweep;
   } req_type;

   typedef struct packed {
      logic signed [31:0] c_new;
      logic signed [31:0] residual;
      logic signed [31:0] slope;
      logic pair_done;
      logic [30:0] pair_rel_error;
      logic [9:0] worst_index;
      logic [30:0] sweep_rel_error;
   } rsp_type;

   // classified command between front and back
   typedef struct packed {
      req_type req;
      logic use_py;
      logic use_kh_pos;
      logic signed [32:0] exp_arg;
   } cmd_type;

endpackage

@@ rtl/closure_update_error_tracker_unit.sv @@
// Closure update and error tracker, top level.
// Each transaction passes the 10-term Taylor loop; a masked one skips tracking and division,
// and the last point of a pair adds the 56-step restoring divider.
// One transaction at a time; the back end stalls while a result waits. A two-entry queue
// decouples input. Synchronous active-high reset restores register defaults and pair state.
// Depends on cuet_pkg, cuet_front, cuet_back.
module closure_update_error_tracker_unit (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  cuet_pkg::req_type req_data,
   output logic empty,
   input  logic pop,
   output cuet_pkg::rsp_type rsp_data,
   input  logic csr_write,
   input  logic [1:0] csr_index,
   input  logic [30:0] csr_data
);
   import cuet_pkg::*;

   logic [1:0] kind_ff;
   logic [30:0] limit_ff;
   logic [25:0] damp_ff;
   logic upd_ff;
   logic cmd_valid, cmd_pop, rsp_valid;
   cmd_type cmd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= CLOSURE_HNC;
         limit_ff <= Sat31;
         damp_ff <= 26'd16777216;
         upd_ff <= 1'b1;
      end else if (csr_write) begin
         case (reg_index_type'(csr_index))
            REG_CLOSURE: kind_ff <= csr_data[1:0];
            REG_LIMIT:   limit_ff <= csr_data;
            REG_DAMPING: damp_ff <= csr_data[25:0];
            REG_UPDATE:  upd_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   cuet_front u_front (
      .clock, .reset, .push, .full, .req_data,
      .closure_kind(kind_ff), .cmd_valid, .cmd_data, .cmd_pop
   );

   cuet_back u_back (
      .clock, .reset, .cmd_valid, .cmd_data, .cmd_pop,
      .cr_limit(limit_ff), .damping(damp_ff), .update_enable(upd_ff),
      .rsp_valid, .rsp_data, .rsp_pop(pop)
   );

   assign empty = !rsp_valid;
endmodule

@@ rtl/cuet_front.sv @@
// Front end: accepts transactions, selects the closure and exponent argument.
// Depends on cuet_pkg. Feeds a two-entry command queue.
module cuet_front (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  cuet_pkg::req_type req_data,
   input  logic [1:0] closure_kind,
   output logic cmd_valid,
   output cuet_pkg::cmd_type cmd_data,
   input  logic cmd_pop
);
   import cuet_pkg::*;

   cmd_type q_ff [2];
   cmd_type q_in;
   logic [1:0] cnt_ff;
   logic rd_ff, wr_ff;
   logic do_push, do_pop;
   logic signed [32:0] delta;

   assign full = (cnt_ff == 2'd2);
   assign do_push = push && !full;
   assign do_pop = cmd_pop && cmd_valid;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data = q_ff[rd_ff];

   always_comb begin
      delta = 33'(req_data.t_value) - 33'(req_data.short_potential);
      q_in.req = req_data;
      q_in.use_py = (closure_kind == CLOSURE_PY);
      q_in.use_kh_pos = (closure_kind == CLOSURE_KH) && (delta > 0);
      q_in.exp_arg = q_in.use_py ? -33'(req_data.short_potential) : delta;
   end

   always_ff @(posedge clock) begin
      if (do_push) q_ff[wr_ff] <= q_in;
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         if (do_push) wr_ff <= !wr_ff;
         if (do_pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(do_push) - 2'(do_pop);
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue overfull");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |=> cnt_ff != 2'd0) else $error("full dropped to empty");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> !cmd_valid) else $error("valid while empty");
endmodule

@@ rtl/cuet_back.sv @@
// Back end: sequencer for exp, closure, update, tracking and pair division.
// Depends on cuet_pkg. Its multiplies are separate operators, not one shared multiplier.
module cuet_back (
   input  logic clock,
   input  logic reset,
   input  logic cmd_valid,
   input  cuet_pkg::cmd_type cmd_data,
   output logic cmd_pop,
   input  logic [30:0] cr_limit,
   input  logic [25:0] damping,
   input  logic update_enable,
   output logic rsp_valid,
   output cuet_pkg::rsp_type rsp_data,
   input  logic rsp_pop
);
   import cuet_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_EXP_Y, S_TDIV, S_TAYLOR, S_EXP_SH, S_PY, S_CR, S_UPD, S_TRACK,
      S_DIV, S_OUT
   } state_type;

   state_type state_ff;
   cmd_type cmd_ff;
   logic signed [63:0] y_ff;
   logic [29:0] u_ff;
   logic [31:0] term_ff;
   logic [29:0] tq_ff;
   logic [34:0] sum_ff;
   logic [3:0] n_ff;
   logic signed [33:0] xp_ff;
   logic signed [65:0] prod_ff;
   logic signed [40:0] cr_ff;
   logic signed [33:0] slope_ff;
   logic signed [31:0] res_ff, cnew_ff;
   logic [31:0] pmr_ff, pmm_ff;
   logic [9:0] pwi_ff, pc_ff;
   logic [30:0] sweep_ff;
   logic [55:0] rem_ff;
   logic [55:0] quo_ff;
   logic [5:0] dcnt_ff;
   logic [32:0] div_ff;
   logic rvalid_ff;
   rsp_type rsp_ff;

   logic signed [31:0] k;
   logic signed [31:0] sh;
   logic [63:0] tprod;
   logic [29:0] tdiv;
   logic [63:0] sumw;
   logic signed [40:0] lim, crc;
   logic signed [33:0] res_w;
   logic signed [59:0] dprod;
   logic signed [34:0] cn_w;
   logic [31:0] rmag, cmag;
   logic [56:0] rem_sh;
   logic [30:0] rel;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      if (v > 36'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -36'sh0_8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // floor(x / n) for n in 1..10 by shift or reciprocal multiply
   function automatic logic [29:0] div_small(input logic [29:0] x, input logic [3:0] n);
      logic [32:0] m;
      m = '0;
      case (n)
         4'd1: return x;
         4'd2: return x >> 1;
         4'd4: return x >> 2;
         4'd8: return x >> 3;
         4'd3: m = 33'd5726623062;
         4'd5: m = 33'd3435973837;
         4'd6: m = 33'd2863311531;
         4'd7: m = 33'd2454267027;
         4'd9: m = 33'd1908874354;
         4'd10: m = 33'd1717986919;
         default: m = '0;
      endcase
      return 30'((64'(x) * 64'(m)) >> 34);
   endfunction

   assign cmd_pop = (state_ff == S_IDLE) && cmd_valid;
   assign rsp_valid = rvalid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      k = 32'(y_ff >>> FracBits);
      sh = k + 32'(FracBits) - 32'sd30;
      tprod = 64'(term_ff) * 64'(u_ff);
      tdiv = div_small(tq_ff, n_ff);
      sumw = 64'(sum_ff);
      lim = 41'(cr_limit);
      crc = cr_ff > lim ? lim : (cr_ff < -lim ? -lim : cr_ff);
      res_w = 34'(crc) - 34'(cmd_ff.req.c_old);
      dprod = 60'(signed'({1'b0, damping})) * 60'(res_ff);
      cn_w = 35'(cmd_ff.req.c_old) + 35'(dprod >>> FracBits);
      rmag = res_ff[31] ? 32'(-33'(res_ff)) : 32'(res_ff);
      cmag = cnew_ff[31] ? 32'(-33'(cnew_ff)) : 32'(cnew_ff);
      rem_sh = {rem_ff, quo_ff[55]};
      rel = (quo_ff > 56'(Sat31)) ? Sat31 : quo_ff[30:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rvalid_ff <= 1'b0;
         dcnt_ff <= '0;
         pmr_ff <= '0; pmm_ff <= '0; pwi_ff <= '0; pc_ff <= '0; sweep_ff <= '0;
      end else begin
         if (state_ff == S_OUT && (!rvalid_ff || rsp_pop)) rvalid_ff <= 1'b1;
         else if (rsp_pop) rvalid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (cmd_valid) begin
               cmd_ff <= cmd_data;
               if (cmd_data.req.new_sweep) sweep_ff <= '0;
               y_ff <= (64'(cmd_data.exp_arg) * 64'(signed'({1'b0, Log2eQ30}))) >>> 30;
               state_ff <= S_EXP_Y;
            end
            S_EXP_Y: begin
               u_ff <= 30'((64'(y_ff[FracBits-1:0]) << (30 - FracBits)) * 64'(Ln2Q30) >> 30);
               term_ff <= 32'h4000_0000;
               sum_ff <= 35'h4000_0000;
               n_ff <= 4'd1;
               state_ff <= S_TAYLOR;
            end
            S_TAYLOR: begin
               tq_ff <= tprod[59:30];
               state_ff <= S_TDIV;
            end
            S_TDIV: begin
               term_ff <= 32'(tdiv);
               sum_ff <= sum_ff + 35'(tdiv);
               n_ff <= n_ff + 4'd1;
               if (n_ff == 4'd10) state_ff <= S_EXP_SH;
               else state_ff <= S_TAYLOR;
            end
            S_EXP_SH: begin
               if (sh > 32'sd31) xp_ff <= 34'sh7FFF_FFFF;
               else if (sh >= 0) xp_ff <= ((sumw << sh[4:0]) > 64'h7FFF_FFFF) ?
                  34'sh7FFF_FFFF : 34'(sumw << sh[4:0]);
               else if (sh <= -32'sd63) xp_ff <= '0;
               else xp_ff <= 34'(sumw >> 6'(-sh));
               state_ff <= S_PY;
            end
            S_PY: begin
               prod_ff <= 66'(xp_ff) * 66'(FxOne + 33'(cmd_ff.req.t_value));
               state_ff <= S_CR;
            end
            S_CR: begin
               slope_ff <= cmd_ff.use_kh_pos ? '0 : xp_ff - 34'(FxOne);
               if (cmd_ff.use_kh_pos) cr_ff <= -41'(cmd_ff.req.short_potential);
               else if (cmd_ff.use_py)
                  cr_ff <= 41'(prod_ff >>> FracBits) - 41'(FxOne)
                     - 41'(cmd_ff.req.t_value);
               else cr_ff <= 41'(xp_ff) - 41'(FxOne) - 41'(cmd_ff.req.t_value);
               state_ff <= S_UPD;
            end
            S_UPD: begin
               if (cmd_ff.req.pair_enabled) begin
                  res_ff <= sat32(36'(res_w));
                  state_ff <= S_TRACK;
               end else begin
                  res_ff <= '0; slope_ff <= '0; cnew_ff <= cmd_ff.req.c_old;
                  state_ff <= S_OUT;
               end
            end
            S_TRACK: begin
               if (update_enable) cnew_ff <= sat32(36'(cn_w));
               else cnew_ff <= cmd_ff.req.c_old;
               state_ff <= S_DIV;
               if (rmag > pmr_ff) begin
                  pmr_ff <= rmag; pwi_ff <= pc_ff;
               end
               pc_ff <= pc_ff + 10'd1;
            end
            S_DIV: begin
               if (dcnt_ff == 6'd0) begin
                  if (cmag > pmm_ff) pmm_ff <= cmag;
                  div_ff <= 33'(cmag > pmm_ff ? cmag : pmm_ff) + 33'(FxEps);
                  quo_ff <= 56'(pmr_ff) << FracBits;
                  rem_ff <= '0;
                  if (cmd_ff.req.last_point) dcnt_ff <= 6'd1;
                  else state_ff <= S_OUT;
               end else begin
                  if (rem_sh >= 57'(div_ff)) begin
                     rem_ff <= 56'(rem_sh - 57'(div_ff));
                     quo_ff <= {quo_ff[54:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh[55:0];
                     quo_ff <= {quo_ff[54:0], 1'b0};
                  end
                  if (dcnt_ff == 6'd56) begin
                     dcnt_ff <= 6'd0; state_ff <= S_OUT;
                  end else begin
                     dcnt_ff <= dcnt_ff + 6'd1;
                  end
               end
            end
            S_OUT: if (!rvalid_ff || rsp_pop) begin
               rsp_ff.c_new <= cnew_ff;
               rsp_ff.residual <= res_ff;
               rsp_ff.slope <= slope_ff[31:0];
               if (cmd_ff.req.pair_enabled && cmd_ff.req.last_point) begin
                  rsp_ff.pair_done <= 1'b1;
                  rsp_ff.pair_rel_error <= rel;
                  rsp_ff.worst_index <= pwi_ff;
                  rsp_ff.sweep_rel_error <= rel > sweep_ff ? rel : sweep_ff;
                  if (rel > sweep_ff) sweep_ff <= rel;
                  pmr_ff <= '0; pmm_ff <= '0; pwi_ff <= '0; pc_ff <= '0;
               end else begin
                  rsp_ff.pair_done <= 1'b0;
                  rsp_ff.pair_rel_error <= '0;
                  rsp_ff.worst_index <= '0;
                  rsp_ff.sweep_rel_error <= '0;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> state_ff == S_IDLE) else $error("pop while busy");
   a_out_next: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !rvalid_ff) |=> rvalid_ff) else $error("result lost");
   a_done_fields: assert property (@(posedge clock) disable iff (reset)
      (rvalid_ff && !rsp_ff.pair_done) |-> rsp_ff.worst_index == '0)
      else $error("error fields set without pair_done");
endmodule
